@@ design/pidc_pkg.sv @@
// Package for the PID step block: stage payload types, register indexes and the
// symmetric clamp shared by the integral and output stages. No dependencies.
`default_nettype none
package pidc_pkg;

    localparam int DataW  = 32;
    localparam int LimW   = 31;
    localparam int DiffW  = 33;
    localparam int TermW  = 48;
    localparam int DTermW = 49;
    localparam int SumW   = 50;
    localparam int IdxW   = 2;

    localparam logic [IdxW-1:0] REG_KP = 2'd0;
    localparam logic [IdxW-1:0] REG_KI = 2'd1;
    localparam logic [IdxW-1:0] REG_KD = 2'd2;

    typedef struct packed {
        logic signed [DataW-1:0] kp;
        logic signed [DataW-1:0] ki;
        logic signed [DataW-1:0] kd;
    } t_gains;

    typedef struct packed {
        logic signed [DataW-1:0] err;
        logic signed [DiffW-1:0] diff;
        logic [LimW-1:0]         lim;
    } t_s1;

    typedef struct packed {
        logic signed [TermW-1:0]  p;
        logic signed [TermW-1:0]  i;
        logic signed [DTermW-1:0] d;
        logic [LimW-1:0]          lim;
    } t_s2;

    typedef struct packed {
        logic signed [TermW-1:0]  p;
        logic signed [DTermW-1:0] d;
        logic signed [DataW-1:0]  integ;
        logic [LimW-1:0]          lim;
    } t_s3;

    function automatic logic signed [DataW-1:0] clamp_sym(
        input logic signed [SumW-1:0] v,
        input logic [LimW-1:0]        lim
    );
        logic signed [SumW-1:0]  pos;
        logic signed [SumW-1:0]  neg;
        logic signed [DataW-1:0] res;
        pos = signed'({{(SumW-LimW){1'b0}}, lim});
        neg = -pos;
        priority if (v > pos) begin
            res = pos[DataW-1:0];
        end else if (v < neg) begin
            res = neg[DataW-1:0];
        end else begin
            res = v[DataW-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ design/pid_step_with_clamps_top.sv @@
// Top level of the PID step block: gain registers, input register and the stage chain.
// Depends on pidc_pkg, pidc_mult, pidc_integ and pidc_out.
//
// One PID step per item: each item carries a signed Q16.16 error and a limit, and
// yields one clamped drive value. The block takes a new item every cycle unless the output
// stalls it; an item passes four registers (input register, multiply stage, integral
// stage, output register) before its result is presented. Each stage holds its item only
// while the one after it is full and stalled. The integral and the previous error reset to
// zero, as do the three gains. Gains are to be written through the configuration port
// only while idle; the block itself does not enforce this.
`default_nettype none
module pid_step_with_clamps_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wen,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // [31:0] error_value, [62:32] output_limit
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata    // [31:0] drive_value
);

    pidc_pkg::t_gains                  r_gains;
    logic signed [pidc_pkg::DataW-1:0] r_last_err;
    logic                              r_s1_v;
    pidc_pkg::t_s1                     r_s1;
    logic signed [pidc_pkg::DataW-1:0] n_err;
    logic [pidc_pkg::LimW-1:0]         n_lim;
    logic signed [pidc_pkg::DiffW-1:0] n_diff;
    logic                              s_accept;

    logic                              mul_ready;
    logic                              mul_valid;
    pidc_pkg::t_s2                     mul_data;
    logic                              int_ready;
    logic                              int_valid;
    pidc_pkg::t_s3                     int_data;
    logic                              out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                pidc_pkg::REG_KP: r_gains.kp <= i_cfg_data;
                pidc_pkg::REG_KI: r_gains.ki <= i_cfg_data;
                pidc_pkg::REG_KD: r_gains.kd <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_s_tready = !r_s1_v || mul_ready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_err  = i_s_tdata[31:0];
        n_lim  = i_s_tdata[62:32];
        n_diff = signed'({n_err[pidc_pkg::DataW-1], n_err})
               - signed'({r_last_err[pidc_pkg::DataW-1], r_last_err});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_last_err <= '0;
        end else begin
            if (o_s_tready) begin
                r_s1_v <= i_s_tvalid;
            end
            if (s_accept) begin
                r_last_err <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1.err  <= n_err;
            r_s1.diff <= n_diff;
            r_s1.lim  <= n_lim;
        end
    end

    pidc_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gains (r_gains),
        .i_valid (r_s1_v),
        .i_data  (r_s1),
        .o_ready (mul_ready),
        .o_valid (mul_valid),
        .o_data  (mul_data),
        .i_ready (int_ready)
    );

    pidc_integ u_integ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .i_data  (mul_data),
        .o_ready (int_ready),
        .o_valid (int_valid),
        .o_data  (int_data),
        .i_ready (out_ready)
    );

    pidc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (int_valid),
        .i_data  (int_data),
        .o_ready (out_ready),
        .o_valid (o_m_tvalid),
        .o_drive (o_m_tdata),
        .i_ready (i_m_tready)
    );

endmodule
`default_nettype wire

@@ design/pidc_mult.sv @@
// Multiply stage of the PID step: the three gain products, floored to Q16.16.
// Depends on pidc_pkg.
`default_nettype none
module pidc_mult (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pidc_pkg::t_gains i_gains,
    input  wire logic           i_valid,
    input  wire pidc_pkg::t_s1  i_data,
    output logic                o_ready,
    output logic                o_valid,
    output pidc_pkg::t_s2       o_data,
    input  wire logic           i_ready
);

    logic                 r_v;
    pidc_pkg::t_s2        r_data;
    logic signed [63:0]   n_p;
    logic signed [63:0]   n_i;
    logic signed [64:0]   n_d;

    assign o_ready = !r_v || i_ready;

    always_comb begin
        n_p = i_gains.kp * i_data.err;
        n_i = i_gains.ki * i_data.err;
        n_d = i_gains.kd * i_data.diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data.p   <= n_p[63:16];
            r_data.i   <= n_i[63:16];
            r_data.d   <= n_d[64:16];
            r_data.lim <= i_data.lim;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_data;

endmodule
`default_nettype wire

@@ design/pidc_integ.sv @@
// Integral stage of the PID step: holds the clamped integral sum.
// Depends on pidc_pkg.
`default_nettype none
module pidc_integ (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire pidc_pkg::t_s2 i_data,
    output logic               o_ready,
    output logic               o_valid,
    output pidc_pkg::t_s3      o_data,
    input  wire logic          i_ready
);

    logic                                   r_v;
    logic signed [pidc_pkg::DataW-1:0]      r_int;
    pidc_pkg::t_s3                          r_data;
    logic signed [pidc_pkg::SumW-1:0]       n_sum;
    logic signed [pidc_pkg::DataW-1:0]      n_int;

    assign o_ready = !r_v || i_ready;

    always_comb begin
        n_sum = signed'({{(pidc_pkg::SumW-pidc_pkg::DataW){r_int[pidc_pkg::DataW-1]}}, r_int})
              + signed'({{(pidc_pkg::SumW-pidc_pkg::TermW){i_data.i[pidc_pkg::TermW-1]}},
                         i_data.i});
        n_int = pidc_pkg::clamp_sym(n_sum, i_data.lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_int <= '0;
        end else begin
            if (o_ready) begin
                r_v <= i_valid;
            end
            if (i_valid && o_ready) begin
                r_int <= n_int;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data.p     <= i_data.p;
            r_data.d     <= i_data.d;
            r_data.integ <= n_int;
            r_data.lim   <= i_data.lim;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_data;

endmodule
`default_nettype wire

@@ design/pidc_out.sv @@
// Output stage of the PID step: sums the three terms and clamps the drive.
// Depends on pidc_pkg.
`default_nettype none
module pidc_out (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire pidc_pkg::t_s3 i_data,
    output logic               o_ready,
    output logic               o_valid,
    output logic [pidc_pkg::DataW-1:0] o_drive,
    input  wire logic          i_ready
);

    logic                              r_v;
    logic signed [pidc_pkg::DataW-1:0] r_drive;
    logic signed [pidc_pkg::SumW-1:0]  n_sum;

    localparam int TExt = pidc_pkg::SumW - pidc_pkg::TermW;
    localparam int DExt = pidc_pkg::SumW - pidc_pkg::DTermW;
    localparam int IExt = pidc_pkg::SumW - pidc_pkg::DataW;

    assign o_ready = !r_v || i_ready;

    always_comb begin
        n_sum = signed'({{TExt{i_data.p[pidc_pkg::TermW-1]}}, i_data.p})
              + signed'({{DExt{i_data.d[pidc_pkg::DTermW-1]}}, i_data.d})
              + signed'({{IExt{i_data.integ[pidc_pkg::DataW-1]}}, i_data.integ});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_drive <= pidc_pkg::clamp_sym(n_sum, i_data.lim);
        end
    end

    assign o_valid = r_v;
    assign o_drive = r_drive;

endmodule
`default_nettype wire
